### rtl/s5sts_pkg.sv
package s5sts_pkg;

	localparam int unsigned SLP_TYPE_SHIFT_DEF = 10;
	localparam int unsigned HIST_DEPTH         = 6;
	localparam int unsigned FIELD_W            = 13;

	localparam logic [7:0] NAME_OP     = 8'h08;
	localparam logic [7:0] ROOT_PREFIX = 8'h5C;
	localparam logic [7:0] PACKAGE_OP  = 8'h12;
	localparam logic [7:0] BYTE_PREFIX = 8'h0A;
	localparam logic [7:0] CHAR_US     = 8'h5F;
	localparam logic [7:0] CHAR_S      = 8'h53;
	localparam logic [7:0] CHAR_5      = 8'h35;

	localparam logic STATUS_FOUND     = 1'b0;
	localparam logic STATUS_NOT_FOUND = 1'b1;

	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_LEAD,
		PH_MORE,
		PH_COUNT,
		PH_A_PRE,
		PH_A_VAL,
		PH_B_PRE,
		PH_B_VAL
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} scan_in_t;

	typedef struct packed {
		logic               status;
		logic [FIELD_W-1:0] sleep_type_a;
		logic [FIELD_W-1:0] sleep_type_b;
	} scan_res_t;

endpackage

### rtl/s5sts_in_stage.sv
module s5sts_in_stage
	import s5sts_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     src_valid,
	output logic     src_stall,
	input  scan_in_t src_word,
	input  logic     take,
	output logic     valid_s1,
	output scan_in_t word_s1
);

	logic valid_s1_q;

	// hold the word while the parser cannot consume it
	assign src_stall = valid_s1_q && !take;
	assign valid_s1  = valid_s1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (!src_stall) begin
			valid_s1_q <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			word_s1 <= src_word;
		end
	end

endmodule

### rtl/s5sts_parser.sv
module s5sts_parser
	import s5sts_pkg::*;
#(
	parameter int unsigned SLP_TYPE_SHIFT = SLP_TYPE_SHIFT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_s1,
	input  scan_in_t  word_s1,
	output logic      take,
	output logic      res_valid,
	input  logic      res_stall,
	output scan_res_t res_word
);

	logic [7:0] hist_q [HIST_DEPTH];
	logic [2:0] seen_q, seen_d;
	phase_t     phase_q, phase_d;
	logic [1:0] len_q, len_d;
	logic [2:0] first_q, first_d;
	logic       answered_q, answered_d;
	logic       res_valid_q;

	logic       name_hit;
	logic       found;
	logic       emit;
	logic       push;
	scan_res_t  res_d;
	logic [7:0] b;

	function automatic logic [FIELD_W-1:0] place_type(input logic [2:0] v);
		logic [FIELD_W+2:0] w;
		w = {{FIELD_W{1'b0}}, v} << SLP_TYPE_SHIFT;
		return w[FIELD_W-1:0];
	endfunction

	assign b    = word_s1.data_byte;
	assign take = valid_s1 && (!res_valid_q || !res_stall);

	// NameOp, optional root prefix, then _S5_ at the young end of the history
	assign name_hit = (seen_q >= 3'd5) && hist_q[2] == CHAR_US && hist_q[3] == CHAR_S
		&& hist_q[4] == CHAR_5 && hist_q[5] == CHAR_US
		&& (hist_q[1] == NAME_OP
			|| (seen_q >= 3'd6 && hist_q[0] == NAME_OP && hist_q[1] == ROOT_PREFIX));

	assign found = !answered_q
		&& ((phase_q == PH_B_PRE && b != BYTE_PREFIX) || phase_q == PH_B_VAL);
	assign push  = !answered_q && phase_q == PH_SEARCH
		&& !(b == PACKAGE_OP && name_hit);

	// next state
	always_comb begin
		phase_d    = phase_q;
		len_d      = len_q;
		first_d    = first_q;
		answered_d = answered_q;
		seen_d     = seen_q;
		if (push && seen_q < 3'(HIST_DEPTH)) begin
			seen_d = seen_q + 3'd1;
		end
		if (!answered_q) begin
			case (phase_q)
				PH_SEARCH: begin
					if (b == PACKAGE_OP && name_hit) begin
						phase_d = PH_LEAD;
					end
				end
				PH_LEAD: begin
					len_d   = b[7:6];
					phase_d = (b[7:6] != 2'd0) ? PH_MORE : PH_COUNT;
				end
				PH_MORE: begin
					len_d = len_q - 2'd1;
					if (len_q == 2'd1) begin
						phase_d = PH_COUNT;
					end
				end
				PH_COUNT: phase_d = PH_A_PRE;
				PH_A_PRE: begin
					if (b == BYTE_PREFIX) begin
						phase_d = PH_A_VAL;
					end else begin
						first_d = b[2:0];
						phase_d = PH_B_PRE;
					end
				end
				PH_A_VAL: begin
					first_d = b[2:0];
					phase_d = PH_B_PRE;
				end
				PH_B_PRE: begin
					if (b == BYTE_PREFIX) begin
						phase_d = PH_B_VAL;
					end
				end
				PH_B_VAL: phase_d = PH_B_VAL;
				default:  phase_d = PH_SEARCH;
			endcase
		end
		if (found && !word_s1.last_byte) begin
			answered_d = 1'b1;
		end
		// end of region: back to the reset state
		if (word_s1.last_byte) begin
			phase_d    = PH_SEARCH;
			len_d      = 2'd0;
			first_d    = 3'd0;
			answered_d = 1'b0;
			seen_d     = 3'd0;
		end
	end

	// result
	always_comb begin
		emit  = found || (word_s1.last_byte && !answered_q);
		res_d = '0;
		if (found) begin
			res_d.status       = STATUS_FOUND;
			res_d.sleep_type_a = place_type(first_q);
			res_d.sleep_type_b = place_type(b[2:0]);
		end else begin
			res_d.status = STATUS_NOT_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SEARCH;
			len_q      <= 2'd0;
			first_q    <= 3'd0;
			answered_q <= 1'b0;
			seen_q     <= 3'd0;
		end else if (take) begin
			phase_q    <= phase_d;
			len_q      <= len_d;
			first_q    <= first_d;
			answered_q <= answered_d;
			seen_q     <= seen_d;
		end
	end

	// history entries beyond seen_q are never looked at
	always_ff @(posedge clk) begin
		if (take && push) begin
			for (int i = 0; i < HIST_DEPTH - 1; i++) begin
				hist_q[i] <= hist_q[i+1];
			end
			hist_q[HIST_DEPTH-1] <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= emit;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_word <= res_d;
		end
	end

	assign res_valid = res_valid_q;

`ifndef SYNTH
	a_answered_phase: assert property (@(posedge clk) disable iff (!arst_n)
		answered_q |-> (phase_q == PH_B_PRE || phase_q == PH_B_VAL))
		else $error("answered outside value phase");

	a_more_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_MORE |-> len_q != 2'd0)
		else $error("length skip with nothing left");

	a_seen_max: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= 3'(HIST_DEPTH))
		else $error("history count overflow");

	a_found_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(take && emit && res_d.status == STATUS_FOUND)
			|=> (answered_q || phase_q == PH_SEARCH))
		else $error("found result did not close the region");

	a_region_end: assert property (@(posedge clk) disable iff (!arst_n)
		(take && word_s1.last_byte) |=> (phase_q == PH_SEARCH && seen_q == 3'd0))
		else $error("last byte did not clear the scanner");
`endif

endmodule

### rtl/s5_sleep_type_scanner_unit.sv
// channel  direction  handshake                  payload
// src      in         src_valid / src_stall      src_word : scan_in_t  (data_byte, last_byte)
// res      out        res_valid / res_stall      res_word : scan_res_t (status, sleep_type_a/b)
//
// One byte per cycle unless a stalled result holds the parser; a result is valid on the cycle after its byte is taken.
// Throughput is set by the parser: one state update per byte between input and result register.
// arst_n clears the scanner to searching with an empty history; the data registers are not reset.
// A stalled result holds the parser; the input register then raises src_stall while it holds a byte.
// A last byte always ends the region and returns the scanner to its reset state.
module s5_sleep_type_scanner_unit
	import s5sts_pkg::*;
#(
	parameter int unsigned SLP_TYPE_SHIFT = SLP_TYPE_SHIFT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  scan_in_t  src_word,
	output logic      res_valid,
	input  logic      res_stall,
	output scan_res_t res_word
);

	logic     take;
	logic     valid_s1;
	scan_in_t word_s1;

	s5sts_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_word  (src_word),
		.take      (take),
		.valid_s1  (valid_s1),
		.word_s1   (word_s1)
	);

	s5sts_parser #(
		.SLP_TYPE_SHIFT (SLP_TYPE_SHIFT)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.word_s1   (word_s1),
		.take      (take),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

endmodule
